/* hdl/dws_pkg.sv */
// Shared constants, command and status types for the deque with search.
package dws_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int CODE_W = 3;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  localparam logic [FUNC_W-1:0] FUNC_INS_TAIL = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_INS_HEAD = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RM_HEAD  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RM_TAIL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DUMP     = 3'd5;

  localparam logic [CODE_W-1:0] CODE_EMPTY    = 3'd0;
  localparam logic [CODE_W-1:0] CODE_FOUND    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_NOTFOUND = 3'd2;
  localparam logic [CODE_W-1:0] CODE_ELEMENT  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_FULL     = 3'd4;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic              ins_tail;
    logic              ins_head;
    logic              rm_head;
    logic              rm_tail;
    logic              latch_val;
    logic              rd_first;
    logic              rd_next;
    logic              ld_out;
    logic [CODE_W-1:0] out_code;
    logic              out_last;
  } dws_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic at_last;
    logic out_free;
  } dws_stat_t;

  // Circular slot of base + off, with base < DEPTH and off < DEPTH.
  function automatic idx_t slot_add(idx_t base, cnt_t off);
    cnt_t s;
    s = cnt_t'(base) + off;
    if (s >= DEPTH_C) s = s - DEPTH_C;
    return s[IDX_W-1:0];
  endfunction

endpackage

/* hdl/dws_if.sv */
// Valid/ready channel interfaces for commands and results.
interface dws_in_if;
  logic                              valid;
  logic                              ready;
  logic [dws_pkg::FUNC_W-1:0]        func;
  logic signed [dws_pkg::DATA_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);
endinterface

interface dws_out_if;
  logic                              valid;
  logic                              ready;
  logic [dws_pkg::CODE_W-1:0]        code;
  logic signed [dws_pkg::DATA_W-1:0] element;
  logic                              last;

  modport source (output valid, output code, output element, output last, input ready);
  modport sink (input valid, input code, input element, input last, output ready);
endinterface

/* hdl/dws_ctrl.sv */
// Command sequencer: decodes items and steps search and dump walks.
module dws_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [dws_pkg::FUNC_W-1:0] in_func,
  output logic                       in_ready,
  input  dws_pkg::dws_stat_t         stat,
  output dws_pkg::dws_cmd_t          cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [dws_pkg::CODE_W-1:0] res_code_r, res_code_nxt;

  always_comb begin
    state_nxt    = state_r;
    res_code_nxt = res_code_r;
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_func)
            dws_pkg::FUNC_INS_TAIL, dws_pkg::FUNC_INS_HEAD: begin
              if (stat.full) begin
                res_code_nxt = dws_pkg::CODE_FULL;
                state_nxt    = S_RES;
              end else if (in_func == dws_pkg::FUNC_INS_TAIL) begin
                cmd.ins_tail = 1'b1;
              end else begin
                cmd.ins_head = 1'b1;
              end
            end
            dws_pkg::FUNC_RM_HEAD: cmd.rm_head = !stat.empty;
            dws_pkg::FUNC_RM_TAIL: cmd.rm_tail = !stat.empty;
            dws_pkg::FUNC_SEARCH, dws_pkg::FUNC_DUMP: begin
              if (stat.empty) begin
                res_code_nxt = dws_pkg::CODE_EMPTY;
                state_nxt    = S_RES;
              end else begin
                cmd.latch_val = 1'b1;
                cmd.rd_first  = 1'b1;
                state_nxt     = (in_func == dws_pkg::FUNC_SEARCH) ? S_SRCH : S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_SRCH: begin
        if (stat.match) begin
          res_code_nxt = dws_pkg::CODE_FOUND;
          state_nxt    = S_RES;
        end else if (stat.at_last) begin
          res_code_nxt = dws_pkg::CODE_NOTFOUND;
          state_nxt    = S_RES;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_DUMP: begin
        // hold the fetched entry until the output register frees up
        if (stat.out_free) begin
          cmd.ld_out   = 1'b1;
          cmd.out_code = dws_pkg::CODE_ELEMENT;
          cmd.out_last = stat.at_last;
          if (stat.at_last) state_nxt = S_IDLE;
          else cmd.rd_next = 1'b1;
        end
      end
      S_RES: begin
        if (stat.out_free) begin
          cmd.ld_out   = 1'b1;
          cmd.out_code = res_code_r;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      res_code_r <= dws_pkg::CODE_EMPTY;
    end else begin
      state_r    <= state_nxt;
      res_code_r <= res_code_nxt;
    end
  end

endmodule

/* hdl/dws_dp.sv */
// Datapath: entry memory, head pointer, occupancy, walk counter, result register.
module dws_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [dws_pkg::DATA_W-1:0] in_value,
  input  dws_pkg::dws_cmd_t                 cmd,
  output dws_pkg::dws_stat_t                stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dws_pkg::CODE_W-1:0]        out_code,
  output logic signed [dws_pkg::DATA_W-1:0] out_element,
  output logic                              out_last
);

  logic [dws_pkg::DATA_W-1:0] mem [dws_pkg::DEPTH];

  dws_pkg::idx_t front_r, front_nxt;
  dws_pkg::cnt_t occ_r, occ_nxt;
  dws_pkg::idx_t k_r, k_nxt;
  logic [dws_pkg::DATA_W-1:0] val_r;
  logic [dws_pkg::DATA_W-1:0] rdata_r;

  logic                       out_valid_r;
  logic [dws_pkg::CODE_W-1:0] out_code_r;
  logic [dws_pkg::DATA_W-1:0] out_elem_r;
  logic                       out_last_r;

  dws_pkg::idx_t front_dec, front_inc, waddr, raddr;
  logic          we, re;

  always_comb begin
    front_dec = (front_r == '0) ? dws_pkg::idx_t'(dws_pkg::DEPTH - 1) : front_r - 1'b1;
    front_inc = (front_r == dws_pkg::idx_t'(dws_pkg::DEPTH - 1)) ? '0 : front_r + 1'b1;
    we        = cmd.ins_tail || cmd.ins_head;
    waddr     = cmd.ins_head ? front_dec : dws_pkg::slot_add(front_r, occ_r);
    re        = cmd.rd_first || cmd.rd_next;
    raddr     = cmd.rd_first ? front_r
                             : dws_pkg::slot_add(front_r, dws_pkg::cnt_t'(k_r) + 1'b1);

    front_nxt = front_r;
    occ_nxt   = occ_r;
    if (cmd.ins_head) front_nxt = front_dec;
    if (cmd.rm_head)  front_nxt = front_inc;
    if (we) occ_nxt = occ_r + 1'b1;
    if (cmd.rm_head || cmd.rm_tail) occ_nxt = occ_r - 1'b1;

    k_nxt = k_r;
    if (cmd.rd_first)     k_nxt = '0;
    else if (cmd.rd_next) k_nxt = k_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= in_value;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r <= front_nxt;
      occ_r   <= occ_nxt;
      if (cmd.ld_out)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (cmd.latch_val) val_r <= in_value;
    if (cmd.ld_out) begin
      out_code_r <= cmd.out_code;
      out_elem_r <= (cmd.out_code == dws_pkg::CODE_ELEMENT) ? rdata_r : '0;
      out_last_r <= cmd.out_last;
    end
  end

  always_comb begin
    stat.empty    = (occ_r == '0);
    stat.full     = (occ_r >= dws_pkg::DEPTH_C);
    stat.match    = (rdata_r == val_r);
    stat.at_last  = (dws_pkg::cnt_t'(k_r) == occ_r - 1'b1);
    stat.out_free = !out_valid_r || out_ready;
  end

  assign out_valid   = out_valid_r;
  assign out_code    = out_code_r;
  assign out_element = out_elem_r;
  assign out_last    = out_last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= dws_pkg::DEPTH_C)
    else $error("occupancy above depth");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_elem_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_code_r != dws_pkg::CODE_ELEMENT) |-> (out_elem_r == '0))
    else $error("nonzero element on status result");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_first || cmd.rd_next) |-> (occ_r != '0))
    else $error("walk over empty queue");

endmodule

/* hdl/deque_with_search.sv */
// Insert and remove take effect at acceptance; the next item is taken the next cycle.
// A full insert or empty search/dump gives its result through the result state once the output register is free.
// Search reads one entry per cycle through the single memory read port.
// Dump emits one entry per cycle while the sink is ready.
// Reset clears the head pointer, occupancy and output valid; entries stay unwritten, no clear pass.
module deque_with_search (
  input  logic        clk,
  input  logic        rst_n,
  dws_in_if.sink      in_ch,
  dws_out_if.source   out_ch
);

  dws_pkg::dws_cmd_t  cmd;
  dws_pkg::dws_stat_t stat;

  dws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dws_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_value    (in_ch.value),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_code    (out_ch.code),
    .out_element (out_ch.element),
    .out_last    (out_ch.last)
  );

endmodule

/* verif/deque_with_search_tb.sv */
// Self-checking testbench for the deque with search: directed corners, fill to full, random mix.
module deque_with_search_tb;
  import dws_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_RSVD6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_RSVD7 = 3'd7;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20000;

  typedef struct packed {
    logic [CODE_W-1:0]        code;
    logic signed [DATA_W-1:0] element;
    logic                     last;
  } reply_t;

  bit   clk;
  logic rst_n;

  dws_in_if  in_ch ();
  dws_out_if out_ch ();

  deque_with_search u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [DATA_W-1:0] shadow_deque[$];
  reply_t                   replies_due[$];
  int                       fail_count;
  int                       send_idle_pct;
  int                       recv_idle_pct;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * TIMEOUT_CYCLES);
    $display("Verification failed");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Apply one accepted command to the shadow deque and queue the replies it causes.
  function automatic void run_deque_cmd(input logic [FUNC_W-1:0] f,
                                        input logic signed [DATA_W-1:0] v);
    reply_t r;
    bit     hit;
    r = '0;
    r.last = 1'b1;
    case (f)
      FUNC_INS_TAIL: begin
        if (shadow_deque.size() >= DEPTH) begin
          r.code = CODE_FULL;
          replies_due.push_back(r);
        end else begin
          shadow_deque.push_back(v);
        end
      end
      FUNC_INS_HEAD: begin
        if (shadow_deque.size() >= DEPTH) begin
          r.code = CODE_FULL;
          replies_due.push_back(r);
        end else begin
          shadow_deque.push_front(v);
        end
      end
      FUNC_RM_HEAD: begin
        if (shadow_deque.size() != 0) void'(shadow_deque.pop_front());
      end
      FUNC_RM_TAIL: begin
        if (shadow_deque.size() != 0) void'(shadow_deque.pop_back());
      end
      FUNC_SEARCH: begin
        if (shadow_deque.size() == 0) begin
          r.code = CODE_EMPTY;
        end else begin
          hit = 1'b0;
          foreach (shadow_deque[i]) if (shadow_deque[i] == v) hit = 1'b1;
          r.code = hit ? CODE_FOUND : CODE_NOTFOUND;
        end
        replies_due.push_back(r);
      end
      FUNC_DUMP: begin
        if (shadow_deque.size() == 0) begin
          r.code = CODE_EMPTY;
          replies_due.push_back(r);
        end else begin
          foreach (shadow_deque[i]) begin
            r.code = CODE_ELEMENT;
            r.element = shadow_deque[i];
            r.last = (i == shadow_deque.size() - 1);
            replies_due.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic signed [DATA_W-1:0] v);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    run_deque_cmd(f, v);
    @(negedge clk);
  endtask

  // Hold the sender until every pending reply is back, then let a full walk finish.
  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    while (replies_due.size() != 0) @(negedge clk);
    repeat (DEPTH + 4) @(negedge clk);
  endtask

  // Mostly values that repeat, so searches hit; the rest fully random.
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(5))
      0: v = (shadow_deque.size() != 0) ?
             shadow_deque[$urandom_range(shadow_deque.size() - 1)] : $urandom;
      1: v = 32'sh7fffffff;
      2: v = 32'sh80000000;
      3: v = $urandom_range(15) - 8;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic test_directed_corners();
    send_cmd(FUNC_SEARCH, 32'sd5);
    send_cmd(FUNC_DUMP, 32'sd0);
    send_cmd(FUNC_RM_HEAD, 32'sd0);
    send_cmd(FUNC_RM_TAIL, -32'sd1);
    send_cmd(FUNC_RSVD6, 32'sd1);
    send_cmd(FUNC_RSVD7, 32'sd2);
    send_cmd(FUNC_INS_TAIL, 32'sh7fffffff);
    send_cmd(FUNC_INS_HEAD, 32'sh80000000);
    send_cmd(FUNC_INS_TAIL, 32'sd0);
    send_cmd(FUNC_INS_TAIL, -32'sd1);
    send_cmd(FUNC_SEARCH, 32'sh80000000);
    send_cmd(FUNC_SEARCH, 32'sd1);
    send_cmd(FUNC_SEARCH, -32'sd1);
    send_cmd(FUNC_DUMP, 32'sd0);
    send_cmd(FUNC_RM_HEAD, 32'sd0);
    send_cmd(FUNC_RM_TAIL, 32'sd0);
    send_cmd(FUNC_DUMP, 32'sd0);
    send_cmd(FUNC_SEARCH, 32'sh80000000);
    send_cmd(FUNC_RM_HEAD, 32'sd0);
    send_cmd(FUNC_RM_HEAD, 32'sd0);
    send_cmd(FUNC_SEARCH, 32'sd0);
  endtask

  task automatic test_fill_to_full();
    while (shadow_deque.size() < DEPTH)
      send_cmd($urandom_range(1) ? FUNC_INS_HEAD : FUNC_INS_TAIL, $urandom);
    send_cmd(FUNC_INS_TAIL, 32'sh7fffffff);
    send_cmd(FUNC_INS_HEAD, 32'sh80000000);
    send_cmd(FUNC_SEARCH, shadow_deque[DEPTH - 1]);
    send_cmd(FUNC_SEARCH, $urandom);
    send_cmd(FUNC_DUMP, $urandom);
    send_cmd(FUNC_RM_TAIL, $urandom);
    send_cmd(FUNC_RM_HEAD, $urandom);
    send_cmd(FUNC_INS_HEAD, -32'sd1);
    send_cmd(FUNC_INS_TAIL, 32'sd0);
    send_cmd(FUNC_INS_HEAD, 32'sd3);
    send_cmd(FUNC_DUMP, $urandom);
  endtask

  task automatic test_random_mix(input int n_items);
    int                sent;
    int                pick;
    logic [FUNC_W-1:0] f;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 15) f = FUNC_INS_TAIL;
      else if (pick < 30) f = FUNC_INS_HEAD;
      else if (pick < 45) f = FUNC_RM_HEAD;
      else if (pick < 60) f = FUNC_RM_TAIL;
      else if (pick < 82) f = FUNC_SEARCH;
      else if (pick < 94) f = FUNC_DUMP;
      else f = $urandom_range(1) ? FUNC_RSVD6 : FUNC_RSVD7;
      send_cmd(f, pick_value());
      // ignored commands do not count
      if (f != FUNC_RSVD6 && f != FUNC_RSVD7) sent++;
    end
  endtask

  // Result receiver: drop ready at random per phase.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (replies_due.size() == 0) begin
        note_failure($sformatf("unexpected result: code %0d element %0d last %0d",
                               out_ch.code, out_ch.element, out_ch.last));
      end else begin
        want = replies_due.pop_front();
        if (out_ch.code !== want.code || out_ch.element !== want.element ||
            out_ch.last !== want.last)
          note_failure($sformatf(
            "result mismatch: expected code %0d element %0d last %0d, got %0d %0d %0d",
            want.code, want.element, want.last,
            out_ch.code, out_ch.element, out_ch.last));
      end
    end
  end

  initial begin
    reply_t left;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_INS_TAIL;
    in_ch.value = '0;
    rst_n = 1'b0;
    fail_count = 0;
    send_idle_pct = 22;
    recv_idle_pct = 74;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_corners();
    test_fill_to_full();
    test_random_mix(18);
    hold_until_drained();

    send_idle_pct = 74;
    recv_idle_pct = 22;
    test_random_mix(18);
    hold_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(18);

    in_ch.valid <= 1'b0;
    for (int k = 0; k < DRAIN_CYCLES && replies_due.size() != 0; k++) @(negedge clk);
    repeat (DEPTH + 4) @(negedge clk);
    while (replies_due.size() != 0) begin
      left = replies_due.pop_front();
      note_failure($sformatf("missing result: expected code %0d element %0d last %0d",
                             left.code, left.element, left.last));
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
